@@ sv/radial_cosine_vignette_assert.svh @@
// ----------------------------------------------------------------------------
// Radial cosine vignette assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RADIAL_COSINE_VIGNETTE_ASSERT_SVH
`define RADIAL_COSINE_VIGNETTE_ASSERT_SVH

// condition holds at every edge outside reset
`define RCV_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds at the same edge as the antecedent
`define RCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds at the edge after the antecedent
`define RCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rcv_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial cosine vignette package
// Field widths, register indexes, defaults and shared types.
// ----------------------------------------------------------------------------
package rcv_pkg;

    localparam int PIX_W         = 12;
    localparam int DIM_W         = 13;
    localparam int CHAN_W        = 8;
    localparam int SQ_W          = 2 * DIM_W;
    localparam int NUM_W         = SQ_W + 1;
    localparam int MAX_DIM       = 4096;
    localparam int REGION_RESET  = 64;
    localparam int CHAN_MAX      = 255;
    localparam int SERIES_TERMS  = 20;
    localparam int PIPE_LAT_FIXED = 8;

    localparam int GAIN_TABLE_DEPTH_DEF = 1024;
    localparam int GAIN_FRAC_BITS_DEF   = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } chan_set_t;

    typedef enum logic {
        ST_FILL,
        ST_RUN
    } state_t;

endpackage

@@ sv/radial_cosine_vignette.sv @@
// ----------------------------------------------------------------------------
// Radial cosine vignette
// Darkens a pixel by cos^2 of its distance to the region centre, scaled
// to 0.6 of the half-diagonal, through a gain table and three channel lanes.
//
//   channel   signals                                   handshake
//   -------   ---------------------------------------   ----------------------
//   pixel in  pixel_x pixel_y chan_blue/green/red       start && !busy
//   result    out_blue out_green out_red                done, one cycle
//   config    cfg_index cfg_data                        cfg_valid && cfg_ready
//
// One pixel per clock while busy is low; a result passes the front pipeline,
// the one-bit-per-stage index divider, the gain RAM read and the lanes.
// After reset busy stays high while the GAIN_TABLE_DEPTH+1 entry gain
// table is copied into its RAM, one entry per cycle; config writes are taken.
// Results cannot be stalled; done pulses once per accepted pixel.
// ----------------------------------------------------------------------------
module radial_cosine_vignette #(
    parameter int GAIN_TABLE_DEPTH = rcv_pkg::GAIN_TABLE_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS   = rcv_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rcv_pkg::PIX_W-1:0]     pixel_x,
    input  logic [rcv_pkg::PIX_W-1:0]     pixel_y,
    input  logic [rcv_pkg::CHAN_W-1:0]    chan_blue,
    input  logic [rcv_pkg::CHAN_W-1:0]    chan_green,
    input  logic [rcv_pkg::CHAN_W-1:0]    chan_red,
    output logic                          done,
    output logic [rcv_pkg::CHAN_W-1:0]    out_blue,
    output logic [rcv_pkg::CHAN_W-1:0]    out_green,
    output logic [rcv_pkg::CHAN_W-1:0]    out_red,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcv_pkg::DIM_W-1:0]     cfg_data
);

    import rcv_pkg::*;

    localparam int TAB_N  = GAIN_TABLE_DEPTH + 1;
    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int AW     = $clog2(TAB_N);

    function automatic logic [SERIES_TERMS*64-1:0] build_div();
        logic [SERIES_TERMS*64-1:0] v;
        v = '0;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            v[(n-1)*64 +: 64] = 64'd9 * 64'(GAIN_TABLE_DEPTH) * 64'(2 * n - 1) * 64'(2 * n);
        end
        return v;
    endfunction

    localparam logic [SERIES_TERMS*64-1:0] SERIES_DIV = build_div();

    function automatic logic [GAIN_W-1:0] gain_entry(input int k);
        logic [63:0]        term;
        logic [63:0]        k100;
        logic signed [65:0] c;
        logic signed [65:0] g;
        logic [63:0]        gq;
        term = 64'd1 << 32;
        k100 = 64'(k) * 64'd100;
        c    = 66'sh1_0000_0000;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = (term * k100) / SERIES_DIV[(n-1)*64 +: 64];
            if ((n & 1) != 0)
            begin
                c = c - $signed({2'b00, term});
            end
            else
            begin
                c = c + $signed({2'b00, term});
            end
        end
        g = (66'sh1_0000_0000 + c) >>> 1;
        if (g < 66'sd0)
        begin
            g = 66'sd0;
        end
        if (g > 66'sh1_0000_0000)
        begin
            g = 66'sh1_0000_0000;
        end
        gq = 64'(g) + (64'd1 << (31 - GAIN_FRAC_BITS));
        gq = gq >> (32 - GAIN_FRAC_BITS);
        if (gq > (64'd1 << GAIN_FRAC_BITS))
        begin
            gq = 64'd1 << GAIN_FRAC_BITS;
        end
        return gq[GAIN_W-1:0];
    endfunction

    function automatic logic [TAB_N*GAIN_W-1:0] build_rom();
        logic [TAB_N*GAIN_W-1:0] rom;
        rom = '0;
        for (int k = 0; k < TAB_N; k++)
        begin
            rom[k*GAIN_W +: GAIN_W] = gain_entry(k);
        end
        return rom;
    endfunction

    localparam logic [TAB_N*GAIN_W-1:0] GAIN_ROM = build_rom();

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        if (v > DIM_W'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    state_t           state_reg;
    state_t           state_next;
    logic [AW-1:0]    fill_addr_reg;
    logic [AW-1:0]    fill_addr_next;
    logic             fill_we;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [NUM_W-1:0] den_reg;

    logic             accept;
    logic [DIM_W-1:0] twice_x;
    logic [DIM_W-1:0] twice_y;
    logic [DIM_W-1:0] ex;
    logic [DIM_W-1:0] ey;

    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [DIM_W-1:0] ex_reg;
    logic [DIM_W-1:0] ey_reg;
    logic [SQ_W-1:0]  exsq_reg;
    logic [SQ_W-1:0]  eysq_reg;
    logic [NUM_W-1:0] num_reg;
    chan_set_t        chan1_reg;
    chan_set_t        chan2_reg;
    chan_set_t        chan3_reg;

    logic             div_valid;
    logic [AW-1:0]    div_index;
    chan_set_t        div_chan;

    logic [GAIN_W-1:0] gain;
    logic             rv_reg;
    chan_set_t        chan_r_reg;
    logic             lv_reg;
    logic [CHAN_W-1:0] lane_blue;
    logic [CHAN_W-1:0] lane_green;
    logic [CHAN_W-1:0] lane_red;

    logic             done_reg;
    chan_set_t        out_reg;

    // fill sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_addr_next = fill_addr_reg;
        fill_we        = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                fill_we = 1'b1;
                if (fill_addr_reg == AW'(GAIN_TABLE_DEPTH))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    assign busy      = (state_reg == ST_FILL);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(REGION_RESET);
            height_reg <= DIM_W'(REGION_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REGION_WIDTH:  width_reg  <= cfg_data;
                REG_REGION_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign dim_w   = clamp_dim(width_reg);
    assign dim_h   = clamp_dim(height_reg);
    assign twice_x = {pixel_x, 1'b0};
    assign twice_y = {pixel_y, 1'b0};
    assign ex      = (twice_x >= dim_w) ? twice_x - dim_w : dim_w - twice_x;
    assign ey      = (twice_y >= dim_h) ? twice_y - dim_h : dim_h - twice_y;

    // front pipeline: offsets, squares, sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= NUM_W'(SQ_W'(dim_w) * SQ_W'(dim_w)) + NUM_W'(SQ_W'(dim_h) * SQ_W'(dim_h));
        ex_reg    <= ex;
        ey_reg    <= ey;
        chan1_reg <= '{blue: chan_blue, green: chan_green, red: chan_red};
        exsq_reg  <= SQ_W'(ex_reg) * SQ_W'(ex_reg);
        eysq_reg  <= SQ_W'(ey_reg) * SQ_W'(ey_reg);
        chan2_reg <= chan1_reg;
        num_reg   <= NUM_W'(exsq_reg) + NUM_W'(eysq_reg);
        chan3_reg <= chan2_reg;
    end

    rcv_div #(
        .GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .num      (num_reg),
        .den      (den_reg),
        .in_chan  (chan3_reg),
        .out_valid(div_valid),
        .index    (div_index),
        .out_chan (div_chan)
    );

    rcv_ram #(
        .WIDTH(GAIN_W),
        .DEPTH(TAB_N)
    ) u_gain_ram (
        .clk  (clk),
        .we   (fill_we),
        .waddr(fill_addr_reg),
        .wdata(GAIN_ROM[fill_addr_reg*GAIN_W +: GAIN_W]),
        .raddr(div_index),
        .rdata(gain)
    );

    // channel lanes
    rcv_lane #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane_blue (
        .clk   (clk),
        .chan  (chan_r_reg.blue),
        .gain  (gain),
        .scaled(lane_blue)
    );

    rcv_lane #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane_green (
        .clk   (clk),
        .chan  (chan_r_reg.green),
        .gain  (gain),
        .scaled(lane_green)
    );

    rcv_lane #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane_red (
        .clk   (clk),
        .chan  (chan_r_reg.red),
        .gain  (gain),
        .scaled(lane_red)
    );

    // merge lanes into the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg   <= 1'b0;
            lv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rv_reg   <= div_valid;
            lv_reg   <= rv_reg;
            done_reg <= lv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_r_reg <= div_chan;
        out_reg    <= '{blue: lane_blue, green: lane_green, red: lane_red};
    end

    assign done      = done_reg;
    assign out_blue  = out_reg.blue;
    assign out_green = out_reg.green;
    assign out_red   = out_reg.red;

endmodule

@@ sv/rcv_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rcv_div.sv @@
// ----------------------------------------------------------------------------
// Radial cosine vignette table index divider
// Pipelined restoring division giving the rounded, saturated table index
// round(num * DEPTH / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module rcv_div #(
    parameter int GAIN_TABLE_DEPTH = rcv_pkg::GAIN_TABLE_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic [rcv_pkg::NUM_W-1:0]                 num,
    input  logic [rcv_pkg::NUM_W-1:0]                 den,
    input  rcv_pkg::chan_set_t                        in_chan,
    output logic                                      out_valid,
    output logic [$clog2(GAIN_TABLE_DEPTH+1)-1:0]     index,
    output rcv_pkg::chan_set_t                        out_chan
);

    import rcv_pkg::*;

    localparam int QB    = $clog2(GAIN_TABLE_DEPTH + 1);
    localparam int TWO_D = 2 * GAIN_TABLE_DEPTH;
    localparam int N_W   = NUM_W + $clog2(TWO_D) + 1;
    localparam int DS_W  = NUM_W + 1 + QB;
    localparam int CMP_W = (N_W > DS_W) ? N_W : DS_W;

    logic [CMP_W-1:0] dv_ext;
    logic [N_W-1:0]   n_reg;
    logic             pv_reg;
    chan_set_t        pchan_reg;

    logic             vld_reg  [QB+1];
    logic             sat_reg  [QB+1];
    logic [QB-1:0]    q_reg    [QB+1];
    chan_set_t        chan_reg [QB+1];
    logic [CMP_W-1:0] rem_reg  [QB];

    logic [CMP_W-1:0] trial [QB];
    logic [QB-1:0]    take;

    assign dv_ext = CMP_W'({den, 1'b0});

    always_comb
    begin
        for (int s = 0; s < QB; s++)
        begin
            trial[s] = dv_ext << (QB - 1 - s);
            take[s]  = rem_reg[s] >= trial[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            for (int s = 0; s <= QB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            pv_reg     <= in_valid;
            vld_reg[0] <= pv_reg;
            for (int s = 0; s < QB; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= N_W'(num) * N_W'(TWO_D) + N_W'(den);
        pchan_reg   <= in_chan;
        rem_reg[0]  <= CMP_W'(n_reg);
        sat_reg[0]  <= CMP_W'(n_reg) >= (dv_ext << QB);
        q_reg[0]    <= '0;
        chan_reg[0] <= pchan_reg;
        for (int s = 0; s < QB; s++)
        begin
            sat_reg[s+1]  <= sat_reg[s];
            chan_reg[s+1] <= chan_reg[s];
            q_reg[s+1]    <= q_reg[s] | (take[s] ? (QB'(1) << (QB - 1 - s)) : '0);
            if (s < QB - 1)
            begin
                rem_reg[s+1] <= take[s] ? rem_reg[s] - trial[s] : rem_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_chan  = chan_reg[QB];
    assign index     = (sat_reg[QB] || (q_reg[QB] > QB'(GAIN_TABLE_DEPTH)))
                       ? QB'(GAIN_TABLE_DEPTH) : q_reg[QB];

endmodule

@@ sv/rcv_lane.sv @@
// ----------------------------------------------------------------------------
// Radial cosine vignette channel lane
// Scale one colour channel by the Q1.F gain, round to nearest, clamp.
// ----------------------------------------------------------------------------
module rcv_lane #(
    parameter int GAIN_FRAC_BITS = rcv_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic [rcv_pkg::CHAN_W-1:0]  chan,
    input  logic [GAIN_FRAC_BITS:0]     gain,
    output logic [rcv_pkg::CHAN_W-1:0]  scaled
);

    import rcv_pkg::*;

    localparam int P_W = CHAN_W + GAIN_FRAC_BITS + 1;
    localparam int R_W = P_W + 1 - GAIN_FRAC_BITS;

    logic [P_W-1:0] prod_reg;
    logic [P_W:0]   rsum;
    logic [R_W-1:0] rnd;

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(chan) * P_W'(gain);
    end

    assign rsum   = (P_W+1)'(prod_reg) + ((P_W+1)'(1) << (GAIN_FRAC_BITS - 1));
    assign rnd    = rsum[P_W:GAIN_FRAC_BITS];
    assign scaled = (rnd > R_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : rnd[CHAN_W-1:0];

endmodule

@@ sv/rcv_checker.sv @@
// ----------------------------------------------------------------------------
// Radial cosine vignette port checker
// Latency, output bound and table-fill behavior seen at the ports.
// ----------------------------------------------------------------------------
`include "radial_cosine_vignette_assert.svh"

module rcv_checker #(
    parameter int GAIN_TABLE_DEPTH = rcv_pkg::GAIN_TABLE_DEPTH_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [rcv_pkg::CHAN_W-1:0] chan_blue,
    input logic [rcv_pkg::CHAN_W-1:0] chan_green,
    input logic [rcv_pkg::CHAN_W-1:0] chan_red,
    input logic                       done,
    input logic [rcv_pkg::CHAN_W-1:0] out_blue,
    input logic [rcv_pkg::CHAN_W-1:0] out_green,
    input logic [rcv_pkg::CHAN_W-1:0] out_red
);

    import rcv_pkg::*;

    localparam int LATENCY = PIPE_LAT_FIXED + $clog2(GAIN_TABLE_DEPTH + 1);

    `RCV_ASSERT_ALWAYS(a_done_latency, clk, rst_n, done == $past(start && !busy, LATENCY), "result beat does not follow its pixel beat at fixed latency")

    `RCV_ASSERT_IMP(a_no_gain, clk, rst_n, done, (out_blue <= $past(chan_blue, LATENCY)) && (out_green <= $past(chan_green, LATENCY)) && (out_red <= $past(chan_red, LATENCY)), "scaled channel exceeds its input channel")

    `RCV_ASSERT_NEXT(a_busy_once, clk, rst_n, !busy, !busy, "busy rose again after the table fill")

endmodule

bind radial_cosine_vignette rcv_checker #(
    .GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)
) u_rcv_checker (.*);
